>>> rtl/core/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg: shared types and constants of the dissipation coefficient block
// Fixed-point constants, cell transaction types and multiplier scale codes.
// ----------------------------------------------------------------------------
package ldc_pkg;

    localparam int unsigned HK_W  = 21;
    localparam int unsigned RT_W  = 32;
    localparam int unsigned OUT_W = 48;

    localparam logic [63:0] Q56_ONE = 64'd1 << 56;
    localparam logic [63:0] Q44_ONE = 64'd1 << 44;
    localparam logic [63:0] K_A205  = (Q56_ONE * 64'd205 + 64'd50000) / 64'd100000;
    localparam logic [63:0] K_B002  = (Q56_ONE + 64'd25) / 64'd50;
    localparam logic [63:0] K_C0016 = (Q56_ONE * 64'd2 + 64'd625) / 64'd1250;
    localparam logic [63:0] K_207   = (Q44_ONE * 64'd207 + 64'd500) / 64'd1000;
    localparam logic [63:0] MAX48   = 64'h0000_7FFF_FFFF_FFFF;

    localparam logic [HK_W-1:0] FOUR_Q16 = 21'd262144;
    localparam logic [RT_W-1:0] RT_ONE   = 32'd256;

    // one restoring division step: partial remainder, dividend bits still
    // to shift in (MSB first), quotient so far, divisor
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] low;
        logic [63:0] quo;
        logic [63:0] dvs;
    } t_div;

    // one digit step of the integer square root
    typedef struct packed {
        logic [63:0] rad;
        logic [63:0] root;
        logic [63:0] bits;
    } t_sqrt;

    typedef enum logic {
        SC_Q44,
        SC_Q56
    } t_scale;

endpackage

>>> rtl/core/ldc_div_cell.sv
// ----------------------------------------------------------------------------
// ldc_div_cell: one restoring division step
// Shift in one dividend bit, compare against the divisor, emit a quotient bit.
// ----------------------------------------------------------------------------
module ldc_div_cell (
    input  logic         i_clk,
    input  ldc_pkg::t_div i_d,
    output ldc_pkg::t_div o_d
);
    import ldc_pkg::*;

    logic [63:0] n_shift;
    logic        n_ge;
    t_div        r_d;

    always_comb begin
        n_shift = {i_d.rem[62:0], i_d.low[63]};
        n_ge    = (n_shift >= i_d.dvs);
    end

    always_ff @(posedge i_clk) begin
        r_d.rem <= n_ge ? (n_shift - i_d.dvs) : n_shift;
        r_d.low <= {i_d.low[62:0], 1'b0};
        r_d.quo <= {i_d.quo[62:0], n_ge};
        r_d.dvs <= i_d.dvs;
    end

    assign o_d = r_d;

endmodule

>>> rtl/core/ldc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ldc_sqrt_cell: one digit step of the integer square root
// Try root plus trial bit against the radicand, advance the trial bit by two.
// ----------------------------------------------------------------------------
module ldc_sqrt_cell (
    input  logic           i_clk,
    input  ldc_pkg::t_sqrt i_s,
    output ldc_pkg::t_sqrt o_s
);
    import ldc_pkg::*;

    logic [63:0] n_sum;
    logic        n_ge;
    t_sqrt       r_s;

    always_comb begin
        n_sum = i_s.root + i_s.bits;
        n_ge  = (i_s.rad >= n_sum);
    end

    always_ff @(posedge i_clk) begin
        r_s.rad  <= n_ge ? (i_s.rad - n_sum) : i_s.rad;
        r_s.root <= n_ge ? ((i_s.root >> 1) + i_s.bits) : (i_s.root >> 1);
        r_s.bits <= i_s.bits >> 2;
    end

    assign o_s = r_s;

endmodule

>>> rtl/core/ldc_mul.sv
// ----------------------------------------------------------------------------
// ldc_mul: pipelined 64x64 multiply with rounded right shift
// Register operands, form four 32x32 partial products, sum with rounding.
// One transaction per cycle.
// ----------------------------------------------------------------------------
module ldc_mul (
    input  logic            i_clk,
    input  ldc_pkg::t_scale i_scale,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    output logic [63:0]     o_p
);
    import ldc_pkg::*;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    t_scale       r_sc0;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    t_scale       r_sc1;
    logic [127:0] r_sum;
    t_scale       r_sc2;
    logic [127:0] n_rnd;

    always_comb begin
        n_rnd = (r_sc1 == SC_Q56) ? (128'(1) << 55) : (128'(1) << 43);
    end

    always_ff @(posedge i_clk) begin
        r_a   <= i_a;
        r_b   <= i_b;
        r_sc0 <= i_scale;
        r_ll  <= 64'(r_a[31:0])  * 64'(r_b[31:0]);
        r_lh  <= 64'(r_a[31:0])  * 64'(r_b[63:32]);
        r_hl  <= 64'(r_a[63:32]) * 64'(r_b[31:0]);
        r_hh  <= 64'(r_a[63:32]) * 64'(r_b[63:32]);
        r_sc1 <= r_sc0;
        r_sum <= 128'(r_ll) + (128'(r_lh) << 32) + (128'(r_hl) << 32)
               + {r_hh, 64'd0} + n_rnd;
        r_sc2 <= r_sc1;
    end

    assign o_p = (r_sc2 == SC_Q56) ? r_sum[119:56] : r_sum[107:44];

endmodule

>>> rtl/core/laminar_dissipation_coefficient_top.sv
// ----------------------------------------------------------------------------
// laminar_dissipation_coefficient_top: laminar dissipation coefficient closure
// Fixed-point Cd = core(hk) / rt with d/dhk and d/drt, fully pipelined.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   input     start / busy         i_shape_param, i_reynolds_theta
//   output    o_strobe (1 cycle)   o_dissip_coef, o_dissip_d_shape,
//                                  o_dissip_d_reynolds, o_reynolds_clamped
//
// One transaction is taken every cycle; busy stays low. The pipeline depth is
// set by the serial chains: the 45-cell reciprocal of the hk >= 4 rational
// term with the three multiplies behind it, then two 48-cell divider rows by
// rt, one after the other for d/drt. The receiver cannot stall: every cell
// hands its data on each cycle. Reset clears the valid line; payload
// registers hold no reset.
//
module laminar_dissipation_coefficient_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [20:0]        i_shape_param,
    input  logic [31:0]        i_reynolds_theta,
    output logic               busy,
    output logic               o_strobe,
    output logic signed [47:0] o_dissip_coef,
    output logic signed [47:0] o_dissip_d_shape,
    output logic signed [47:0] o_dissip_d_reynolds,
    output logic               o_reynolds_clamped
);
    import ldc_pkg::*;

    // pipeline schedule, in cycles after the input register
    localparam int ML     = 3;             // multiplier latency
    localparam int SQ_N   = 32;            // square root digits
    localparam int QR     = 45;            // reciprocal quotient bits
    localparam int QF     = 50;            // rational term quotient bits
    localparam int QC     = 48;            // quotient bits of division by rt
    localparam int T_X4   = 2 * ML;
    localparam int T_SQ   = SQ_N + 1;
    localparam int T_P45  = T_SQ + ML;
    localparam int T_P55  = T_P45 + ML;
    localparam int T_CA   = T_P55 + ML;
    localparam int T_B2   = ML;
    localparam int T_DEN  = 2 * ML;
    localparam int T_REC  = T_DEN + 1 + QR;
    localparam int T_F    = T_DEN + 1 + QF;
    localparam int T_REC2 = T_REC + ML;
    localparam int T_U    = T_REC2 + ML;
    localparam int T_SB   = T_U + ML;
    localparam int T_CB   = T_F + ML;
    localparam int TM     = T_SB;
    localparam int T_CD   = TM + 1 + QC;
    localparam int T_CDR  = T_CD + 1 + QC;
    localparam int LAT    = T_CDR + 1;
    localparam int D_X4   = T_SQ - T_X4;
    localparam int D_B2   = T_DEN - T_B2;
    localparam int D_CA   = TM - T_CA;
    localparam int D_SA   = TM - T_P55;
    localparam int D_CB   = TM - T_CB;
    localparam int D_CD   = T_CDR - T_CD;

    typedef struct packed {
        logic            clamped;
        logic [RT_W-1:0] rt;
        logic [HK_W-1:0] hk;
    } t_side;

    function automatic t_div mk_div(input logic [127:0] num, input int q,
                                    input logic [63:0] dvs);
        t_div d;
        d.rem = 64'(num >> q);
        d.low = 64'(num << (64 - q));
        d.quo = '0;
        d.dvs = dvs;
        return d;
    endfunction

    function automatic logic [47:0] emit(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        m = mag;
        if (m > MAX48) begin
            m = neg ? (MAX48 + 64'd1) : MAX48;
        end
        return neg ? 48'(64'd0 - m) : 48'(m);
    endfunction

    logic        r_vld [LAT];
    t_side       r_side [LAT];
    logic        n_accept;
    logic [31:0] n_rt;

    // front end decode
    logic [18:0] xr0;
    logic [63:0] x0;
    logic [20:0] bb0;
    logic [63:0] b0;

    // small-shape path
    logic [63:0] x2;
    logic [63:0] x4;
    logic [63:0] r_x4d [D_X4];
    t_sqrt       c_sq [SQ_N+1];
    logic [63:0] r_sq;
    logic [63:0] p45;
    logic [63:0] x36;
    logic [63:0] p55;
    logic [63:0] t_a;
    logic [63:0] ca_p;
    logic [63:0] r_ca_d [D_CA];
    logic [63:0] r_sa_d [D_SA];

    // large-shape path
    logic [63:0] b2;
    logic [63:0] r_b2d [D_B2];
    logic [63:0] bk;
    logic [63:0] den;
    t_div        r_rec_in;
    t_div        r_f_in;
    t_div        c_rec [QR+1];
    t_div        c_f [QF+1];
    logic [63:0] rec2;
    logic [63:0] b55;
    logic [63:0] u_bm;
    logic [63:0] v_bm;
    logic [63:0] fk;
    logic [63:0] r_cb_d [D_CB];

    // merge and division by rt
    logic        is_a;
    logic [63:0] core;
    logic [63:0] slope;
    logic [31:0] rt_m;
    logic [31:0] rt_d;
    t_div        r_cd_in;
    t_div        r_cdh_in;
    t_div        r_cdr_in;
    t_div        c_cd [QC+1];
    t_div        c_cdh [QC+1];
    t_div        c_cdr [QC+1];
    logic [63:0] r_cd_d [D_CD];
    logic [63:0] r_cdh_d [D_CD];

    logic        r_out_vld;
    logic [47:0] r_o_coef;
    logic [47:0] r_o_dh;
    logic [47:0] r_o_dr;
    logic        r_o_clamp;

    // ---------------------------------------------------------------- intake
    assign busy     = 1'b0;
    assign n_accept = start && !busy;
    assign n_rt     = (i_reynolds_theta < RT_ONE) ? RT_ONE : i_reynolds_theta;

    // valid line: the only control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= n_accept;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
            r_out_vld <= r_vld[T_CDR];
        end
    end

    // side data travels with each transaction; stages tap it where needed
    always_ff @(posedge i_clk) begin
        r_side[0].clamped <= (i_reynolds_theta < RT_ONE);
        r_side[0].rt      <= n_rt;
        r_side[0].hk      <= i_shape_param;
        for (int i = 1; i < LAT; i++) r_side[i] <= r_side[i-1];
    end

    always_comb begin
        xr0 = 19'(FOUR_Q16 - r_side[0].hk);
        x0  = 64'(xr0) << 28;
        bb0 = r_side[0].hk - FOUR_Q16;
        b0  = 64'(bb0) << 28;
    end

    // ------------------------------------------------ hk below 4: powers
    ldc_mul u_x2 (.i_clk, .i_scale(SC_Q44), .i_a(x0), .i_b(x0), .o_p(x2));
    ldc_mul u_x4 (.i_clk, .i_scale(SC_Q44), .i_a(x2), .i_b(x2), .o_p(x4));

    // square root of (4-hk) as a row of digit cells
    assign c_sq[0].rad  = 64'(xr0) << 44;
    assign c_sq[0].root = '0;
    assign c_sq[0].bits = 64'd1 << 62;

    for (genvar gi = 0; gi < SQ_N; gi++) begin : g_sq
        ldc_sqrt_cell u_cell (.i_clk, .i_s(c_sq[gi]), .o_s(c_sq[gi+1]));
    end

    // round the root to nearest, hold x^4 until the root is done
    always_ff @(posedge i_clk) begin
        r_sq <= (c_sq[SQ_N].rad > c_sq[SQ_N].root) ? (c_sq[SQ_N].root + 64'd1)
                                                   : c_sq[SQ_N].root;
        r_x4d[0] <= x4;
        for (int i = 1; i < D_X4; i++) r_x4d[i] <= r_x4d[i-1];
    end

    assign x36 = 64'(19'(FOUR_Q16 - r_side[T_P45].hk)) << 28;

    ldc_mul u_p45 (.i_clk, .i_scale(SC_Q44), .i_a(r_x4d[D_X4-1]), .i_b(r_sq << 14),
                   .o_p(p45));
    ldc_mul u_p55 (.i_clk, .i_scale(SC_Q44), .i_a(p45), .i_b(x36), .o_p(p55));
    ldc_mul u_ta  (.i_clk, .i_scale(SC_Q56), .i_a(p45), .i_b(K_A205), .o_p(t_a));
    ldc_mul u_ca  (.i_clk, .i_scale(SC_Q56), .i_a(p55), .i_b(K_A205), .o_p(ca_p));

    // slope gets the factor 5.5 as (11 t + 1) / 2; hold both until the merge
    always_ff @(posedge i_clk) begin
        r_ca_d[0] <= ca_p + K_207;
        for (int i = 1; i < D_CA; i++) r_ca_d[i] <= r_ca_d[i-1];
        r_sa_d[0] <= (t_a * 64'd11 + 64'd1) >> 1;
        for (int i = 1; i < D_SA; i++) r_sa_d[i] <= r_sa_d[i-1];
    end

    // ------------------------------------------ hk at 4 and above: rational
    ldc_mul u_b2 (.i_clk, .i_scale(SC_Q44), .i_a(b0), .i_b(b0), .o_p(b2));
    ldc_mul u_bk (.i_clk, .i_scale(SC_Q56), .i_a(b2), .i_b(K_B002), .o_p(bk));

    assign den = Q44_ONE + bk;

    // launch 1/den and b^2/den into their divider rows
    always_ff @(posedge i_clk) begin
        r_b2d[0] <= b2;
        for (int i = 1; i < D_B2; i++) r_b2d[i] <= r_b2d[i-1];
        r_rec_in <= mk_div((128'(1) << 88) + 128'(den >> 1), QR, den);
        r_f_in   <= mk_div((128'(r_b2d[D_B2-1]) << 44) + 128'(den >> 1), QF, den);
    end

    assign c_rec[0] = r_rec_in;
    assign c_f[0]   = r_f_in;

    for (genvar gi = 0; gi < QR; gi++) begin : g_rec
        ldc_div_cell u_cell (.i_clk, .i_d(c_rec[gi]), .o_d(c_rec[gi+1]));
    end

    for (genvar gi = 0; gi < QF; gi++) begin : g_f
        ldc_div_cell u_cell (.i_clk, .i_d(c_f[gi]), .o_d(c_f[gi+1]));
    end

    assign b55 = 64'(21'(r_side[T_REC2].hk - FOUR_Q16)) << 28;

    ldc_mul u_rec2 (.i_clk, .i_scale(SC_Q44), .i_a(c_rec[QR].quo), .i_b(c_rec[QR].quo),
                    .o_p(rec2));
    ldc_mul u_ubm  (.i_clk, .i_scale(SC_Q44), .i_a(b55), .i_b(rec2), .o_p(u_bm));
    ldc_mul u_vbm  (.i_clk, .i_scale(SC_Q56), .i_a(u_bm), .i_b(K_C0016), .o_p(v_bm));
    ldc_mul u_fk   (.i_clk, .i_scale(SC_Q56), .i_a(c_f[QF].quo), .i_b(K_C0016),
                    .o_p(fk));

    always_ff @(posedge i_clk) begin
        r_cb_d[0] <= K_207 - fk;
        for (int i = 1; i < D_CB; i++) r_cb_d[i] <= r_cb_d[i-1];
    end

    // -------------------------------------- merge, then divide by rt twice
    always_comb begin
        is_a  = (r_side[TM].hk < FOUR_Q16);
        core  = is_a ? r_ca_d[D_CA-1] : r_cb_d[D_CB-1];
        slope = is_a ? r_sa_d[D_SA-1] : (v_bm << 1);
        rt_m  = r_side[TM].rt;
        rt_d  = r_side[T_CD].rt;
    end

    always_ff @(posedge i_clk) begin
        r_cd_in  <= mk_div((128'(core) << 8) + 128'(rt_m >> 1), QC, 64'(rt_m));
        r_cdh_in <= mk_div((128'(slope) << 8) + 128'(rt_m >> 1), QC, 64'(rt_m));
        r_cdr_in <= mk_div((128'(c_cd[QC].quo) << 8) + 128'(rt_d >> 1), QC, 64'(rt_d));
    end

    assign c_cd[0]  = r_cd_in;
    assign c_cdh[0] = r_cdh_in;
    assign c_cdr[0] = r_cdr_in;

    for (genvar gi = 0; gi < QC; gi++) begin : g_cd
        ldc_div_cell u_cd  (.i_clk, .i_d(c_cd[gi]),  .o_d(c_cd[gi+1]));
        ldc_div_cell u_cdh (.i_clk, .i_d(c_cdh[gi]), .o_d(c_cdh[gi+1]));
        ldc_div_cell u_cdr (.i_clk, .i_d(c_cdr[gi]), .o_d(c_cdr[gi+1]));
    end

    // hold Cd and dCd/dhk while dCd/drt finishes, then saturate and drive out
    always_ff @(posedge i_clk) begin
        r_cd_d[0]  <= c_cd[QC].quo;
        r_cdh_d[0] <= c_cdh[QC].quo;
        for (int i = 1; i < D_CD; i++) begin
            r_cd_d[i]  <= r_cd_d[i-1];
            r_cdh_d[i] <= r_cdh_d[i-1];
        end
        r_o_coef  <= emit(r_cd_d[D_CD-1], 1'b0);
        r_o_dh    <= emit(r_cdh_d[D_CD-1], 1'b1);
        r_o_dr    <= emit(c_cdr[QC].quo, 1'b1);
        r_o_clamp <= r_side[T_CDR].clamped;
    end

    assign o_strobe            = r_out_vld;
    assign o_dissip_coef       = r_o_coef;
    assign o_dissip_d_shape    = r_o_dh;
    assign o_dissip_d_reynolds = r_o_dr;
    assign o_reynolds_clamped  = r_o_clamp;

    // -------------------------------------------------------------- checks
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT + 1))
        else $error("result strobe without a matching start");

    a_clamp_flag_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_reynolds_clamped == $past(i_reynolds_theta < RT_ONE, LAT + 1)))
        else $error("clamp flag out of step with its transaction");

    a_result_signs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!o_dissip_coef[47] &&
                      (o_dissip_d_reynolds[47] || (o_dissip_d_reynolds == '0))))
        else $error("result sign wrong");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for laminar_dissipation_coefficient_top
// Drives shape / Reynolds transactions with random gaps and predicts Cd and
// its two slopes in 64-bit fixed point. Every strobed result is compared
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import ldc_pkg::*;

    localparam int N_RANDOM   = 1830;
    localparam int LATENCY    = 160;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [47:0] coef;
        logic signed [47:0] d_shape;
        logic signed [47:0] d_reynolds;
        logic               clamped;
    } t_cd_result;

    // one transaction as handed to the block, plus any typed-in expectations
    typedef struct {
        logic [HK_W-1:0] hk;
        logic [RT_W-1:0] rt;
        bit              typed;
        logic            clamp;
        bit              flat_slope;
    } t_shape_txn;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [20:0]        i_shape_param = '0;
    logic [31:0]        i_reynolds_theta = '0;
    logic               busy;
    logic               o_strobe;
    logic signed [47:0] o_dissip_coef;
    logic signed [47:0] o_dissip_d_shape;
    logic signed [47:0] o_dissip_d_reynolds;
    logic               o_reynolds_clamped;

    t_shape_txn pending_txns[$];
    t_cd_result expected_cd[$];
    int         mismatches = 0;
    int         idle_cycles = 0;

    laminar_dissipation_coefficient_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .i_shape_param       (i_shape_param),
        .i_reynolds_theta    (i_reynolds_theta),
        .busy                (busy),
        .o_strobe            (o_strobe),
        .o_dissip_coef       (o_dissip_coef),
        .o_dissip_d_shape    (o_dissip_d_shape),
        .o_dissip_d_reynolds (o_dissip_d_reynolds),
        .o_reynolds_clamped  (o_reynolds_clamped)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // round(a*b / 2^s), ties upward
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        return 64'(p >> s);
    endfunction

    // round(a*2^s / d), ties upward
    function automatic logic [63:0] scaled_quotient(logic [63:0] a, int s, logic [63:0] d);
        logic [127:0] num;
        num = ({64'd0, a} << s) + {64'd0, d >> 1};
        return 64'(num / {64'd0, d});
    endfunction

    // square root rounded to nearest
    function automatic logic [63:0] nearest_root(logic [63:0] n);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] rem;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            cand = r | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= {64'd0, n})
                r = cand;
        end
        rem = {64'd0, n} - {64'd0, r} * {64'd0, r};
        if (rem > {64'd0, r})
            r = r + 1;
        return r;
    endfunction

    function automatic logic signed [47:0] saturate_q344(logic [63:0] mag, bit neg);
        logic [63:0] m;
        m = mag;
        if (m > MAX48)
            m = neg ? MAX48 + 64'd1 : MAX48;
        return neg ? 48'(64'd0 - m) : 48'(m);
    endfunction

    function automatic t_cd_result predict_dissipation(logic [HK_W-1:0] hk,
                                                       logic [RT_W-1:0] rt_raw);
        t_cd_result res;
        logic [63:0] rt, h, xr, x, sq, x2, x4, p45, p55, t;
        logic [63:0] b, b2, den, f, rec, rec2, core, slope, cd, cd_h, cd_r;
        h  = {43'd0, hk};
        rt = {32'd0, rt_raw};
        res.clamped = 1'b0;
        // hold Reynolds number at 1.0 from below
        if (rt < 64'(RT_ONE)) begin
            rt = 64'(RT_ONE);
            res.clamped = 1'b1;
        end
        if (h < 64'(FOUR_Q16)) begin
            xr    = 64'(FOUR_Q16) - h;
            x     = xr << 28;
            sq    = nearest_root(xr << 44) << 14;
            x2    = scaled_product(x, x, 44);
            x4    = scaled_product(x2, x2, 44);
            p45   = scaled_product(x4, sq, 44);
            p55   = scaled_product(p45, x, 44);
            t     = scaled_product(p45, K_A205, 56);
            core  = scaled_product(p55, K_A205, 56) + K_207;
            slope = (t * 64'd11 + 64'd1) >> 1;
        end else begin
            b     = (h - 64'(FOUR_Q16)) << 28;
            b2    = scaled_product(b, b, 44);
            den   = Q44_ONE + scaled_product(b2, K_B002, 56);
            f     = scaled_quotient(b2, 44, den);
            rec   = scaled_quotient(Q44_ONE, 44, den);
            rec2  = scaled_product(rec, rec, 44);
            core  = K_207 - scaled_product(f, K_C0016, 56);
            slope = 64'd2 * scaled_product(scaled_product(b, rec2, 44), K_C0016, 56);
        end
        cd   = scaled_quotient(core, 8, rt);
        cd_h = scaled_quotient(slope, 8, rt);
        cd_r = scaled_quotient(cd, 8, rt);
        res.coef       = saturate_q344(cd, 1'b0);
        res.d_shape    = saturate_q344(cd_h, 1'b1);
        res.d_reynolds = saturate_q344(cd_r, 1'b1);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted transaction, check every strobe.
    // Reads happen right after the edge, so they see pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_shape_txn txn;
        t_cd_result want;
        bit         progress;
        progress = 1'b0;
        if (i_rst_n && start && !busy) begin
            progress = 1'b1;
            txn  = pending_txns.pop_front();
            want = predict_dissipation(i_shape_param, i_reynolds_theta);
            // typed-in rows override the predictor
            if (txn.typed) begin
                want.clamped = txn.clamp;
                if (txn.flat_slope)
                    want.d_shape = '0;
            end
            expected_cd.push_back(want);
        end
        if (i_rst_n && o_strobe) begin
            progress = 1'b1;
            if (expected_cd.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: coef=%h", o_dissip_coef);
            end else begin
                want = expected_cd.pop_front();
                if (o_dissip_coef !== want.coef || o_dissip_d_shape !== want.d_shape
                        || o_dissip_d_reynolds !== want.d_reynolds
                        || o_reynolds_clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                                 want.coef, want.d_shape, want.d_reynolds, want.clamped,
                                 o_dissip_coef, o_dissip_d_shape, o_dissip_d_reynolds,
                                 o_reynolds_clamped);
                end
            end
        end
        // watchdog: count cycles in which nothing moves
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("laminar_dissipation_coefficient_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // hand one transaction to the block after a gap, hold until taken
    task automatic send_shape(t_shape_txn txn, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_txns.push_back(txn);
        i_shape_param    <= txn.hk;
        i_reynolds_theta <= txn.rt;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [HK_W-1:0] random_shape();
        case ($urandom_range(0, 5))
            0:       return HK_W'($urandom);
            1, 2:    return HK_W'($urandom_range(0, 262143));
            3:       return HK_W'($urandom_range(262144 - 300, 262144 + 300));
            4:       return HK_W'($urandom_range(262144, 262144 + 20 * 65536));
            default: return (($urandom_range(0, 7) == 0) ? FOUR_Q16 : HK_W'($urandom));
        endcase
    endfunction

    function automatic logic [RT_W-1:0] random_reynolds();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return RT_W'($urandom_range(0, 255));
            2:       return RT_W'($urandom_range(250, 270));
            3:       return RT_W'($urandom_range(256, 256 * 100000));
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // directed rows: extremes, both branches, the hk = 4 seam, the clamp edge
    localparam int N_DIRECTED = 18;
    logic [HK_W-1:0] dir_hk [N_DIRECTED] = '{
        21'd0, 21'h1FFFFF, 21'h1FFFFF, 21'd262144, 21'd262144, 21'd262143,
        21'd262145, 21'd0, 21'd65536, 21'd131072, 21'd196608, 21'd327680,
        21'd655360, 21'd1, 21'h155555, 21'h0AAAAA, 21'd262144, 21'd1048576};
    logic [RT_W-1:0] dir_rt [N_DIRECTED] = '{
        32'd0, 32'hFFFFFFFF, 32'd0, 32'd256, 32'd255, 32'd256,
        32'd256, 32'hFFFFFFFF, 32'd100000, 32'd256000, 32'd257, 32'd1,
        32'hAAAAAAAA, 32'h55555555, 32'd256, 32'd128, 32'hFFFFFFFF, 32'd65536};

    initial begin
        t_shape_txn txn;
        int         gap;
        bit         burst;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: clamp flag is read off the Reynolds value, the slope
        // is exactly zero at hk = 4
        for (int i = 0; i < N_DIRECTED; i++) begin
            txn.hk         = dir_hk[i];
            txn.rt         = dir_rt[i];
            txn.typed      = 1'b1;
            txn.clamp      = (dir_rt[i] < RT_ONE);
            txn.flat_slope = (dir_hk[i] == FOUR_Q16);
            send_shape(txn, $urandom_range(0, 2));
        end

        // random part, in bursts with and without gaps
        burst = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            // drain the pipeline once, midway
            if (i == N_RANDOM / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (expected_cd.size() != 0 || pending_txns.size() != 0)
                    @(posedge i_clk);
            end
            txn.hk    = random_shape();
            txn.rt    = random_reynolds();
            txn.typed = 1'b0;
            gap = burst ? 0 : $urandom_range(0, 17);
            send_shape(txn, gap);
        end
        start <= 1'b0;

        while (expected_cd.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 40) @(posedge i_clk);

        if (mismatches == 0 && expected_cd.size() == 0)
            $display("laminar_dissipation_coefficient_top test passed");
        else
            $display("laminar_dissipation_coefficient_top test failed");
        $finish;
    end

endmodule
